// ===== sv/rbd_pkg.sv =====
// Package for the ring buffer deque: sizes, command and status codes,
// item structures and the per-cell control structure. No dependencies.
package rbd_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_PEEK_BACK  = 3'd4,
		CMD_PEEK_FRONT = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic signed [WORD_W-1:0] EMPTY_DATA = -32'sd1;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [WORD_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_data;
		logic [1:0]               status;
		logic                     is_empty;
		logic                     is_full;
		logic [4:0]               occupancy;
	} rsp_item_t;

	// What one cell loads at the next edge; all clear means hold.
	typedef struct packed {
		logic take_left;
		logic take_right;
		logic take_new;
	} cell_ctrl_t;

endpackage

// ===== sv/rbd_cell.sv =====
// One storage cell of the deque row: holds a word and loads from either
// neighbour or from the pushed word. Depends on rbd_pkg.
module rbd_cell (
	input  logic                             clk,
	input  rbd_pkg::cell_ctrl_t              ctrl,
	input  logic signed [rbd_pkg::WORD_W-1:0] left_data,
	input  logic signed [rbd_pkg::WORD_W-1:0] right_data,
	input  logic signed [rbd_pkg::WORD_W-1:0] new_data,
	output logic signed [rbd_pkg::WORD_W-1:0] data
);
	import rbd_pkg::*;

	logic signed [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.take_new) begin
			data_q <= new_data;
		end else if (ctrl.take_left) begin
			data_q <= left_data;
		end else if (ctrl.take_right) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

// ===== sv/rbd_row.sv =====
// Row of deque cells with the fill count and the command decode that
// steers every cell. Depends on rbd_pkg and rbd_cell.
module rbd_row (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  rbd_pkg::cmd_item_t                cmd,
	output rbd_pkg::rsp_item_t                rsp
);
	import rbd_pkg::*;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic [CNT_W-1:0]         count_m1;
	logic                     empty;
	logic                     full;
	logic                     do_add_rear;
	logic                     do_add_head;
	logic                     do_take_head;
	logic signed [WORD_W-1:0] cell_data [DEPTH];
	logic signed [WORD_W-1:0] back_data;
	logic signed [WORD_W-1:0] read_data;
	logic [1:0]               status;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign count_m1 = count_q - CNT_W'(1);
	assign back_data = cell_data[count_m1[IDX_W-1:0]];

	always_comb begin
		do_add_rear  = 1'b0;
		do_add_head  = 1'b0;
		do_take_head = 1'b0;
		read_data    = '0;
		status       = ST_DONE;
		count_nxt    = count_q;
		case (cmd.command)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_add_rear = (cmd.command == CMD_PUSH_BACK);
					do_add_head = (cmd.command == CMD_PUSH_FRONT);
					count_nxt   = count_q + CNT_W'(1);
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT, CMD_PEEK_BACK, CMD_PEEK_FRONT: begin
				if (empty) begin
					status    = ST_EMPTY;
					read_data = EMPTY_DATA;
				end else begin
					if (cmd.command == CMD_POP_BACK || cmd.command == CMD_PEEK_BACK) begin
						read_data = back_data;
					end else begin
						read_data = cell_data[0];
					end
					if (cmd.command == CMD_POP_BACK || cmd.command == CMD_POP_FRONT) begin
						count_nxt = count_m1;
					end
					do_take_head = (cmd.command == CMD_POP_FRONT);
				end
			end
			default: begin
			end
		endcase
	end

	// Front of the deque is always cell 0, the back is cell count-1.
	// Popping at the back only lowers the count; the stale word is never read.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t               ctrl;
		logic signed [WORD_W-1:0] left_in;
		logic signed [WORD_W-1:0] right_in;

		assign ctrl.take_new   = step & ((do_add_rear && count_q == CNT_W'(i)) ||
			(do_add_head && i == 0));
		assign ctrl.take_left  = step & do_add_head & (i != 0);
		assign ctrl.take_right = step & do_take_head;
		assign left_in  = (i == 0) ? cmd.push_value : cell_data[(i == 0) ? 0 : i - 1];
		assign right_in = (i == DEPTH - 1) ? cell_data[i] :
			cell_data[(i == DEPTH - 1) ? i : i + 1];

		rbd_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_in),
			.right_data (right_in),
			.new_data   (cmd.push_value),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_nxt;
		end
	end

	assign rsp.read_data = read_data;
	assign rsp.status    = status;
	assign rsp.is_empty  = (count_nxt == '0);
	assign rsp.is_full   = (count_nxt == CNT_W'(DEPTH));
	assign rsp.occupancy = 5'(count_nxt);

endmodule

// ===== sv/ring_buffer_deque_top.sv =====
// Top level of the ring buffer deque: command channel in, response channel
// out, a two-entry response buffer. Depends on rbd_pkg and rbd_row.
//
// Usage: the sender presents a command item on cmd_item with cmd_valid;
// it is taken at a rising edge where cmd_valid is high and cmd_stall low.
// Commands are push back, push front, pop back, pop front, peek back and
// peek front on a deque of DEPTH words held in a row of cells, cell 0
// being the front. Every command item yields exactly one response item on
// rsp_item, with rsp_valid, taken when rsp_stall is low.
// An accepted command's response is registered, in the skid register
// if the receiver stalls. Throughput is one command per cycle while
// cmd_stall is low; the cells shift or load in the same cycle the
// command is decoded; the fill count is the only loop between commands.
// When the receiver stalls, the response waits in the output register and
// one further command is still accepted into a skid register; only with
// both occupied is cmd_stall raised, so nothing is lost or repeated.
// Reset (arst_n low) empties the deque and both response registers; the
// stored words themselves are not cleared and are never read before write.
module ring_buffer_deque_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  rbd_pkg::cmd_item_t   cmd_item,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rbd_pkg::rsp_item_t   rsp_item
);
	import rbd_pkg::*;

	logic      accept;
	logic      rsp_take;
	rsp_item_t row_rsp;
	rsp_item_t rsp_q;
	rsp_item_t skid_q;
	logic      rsp_valid_q;
	logic      skid_valid_q;

	// The skid register being full is the only reason to hold off commands.
	assign cmd_stall = skid_valid_q;
	assign accept    = cmd_valid & ~skid_valid_q;
	assign rsp_take  = rsp_valid_q & ~rsp_stall;

	rbd_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cmd    (cmd_item),
		.rsp    (row_rsp)
	);

	// Control flags of the response buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (rsp_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (rsp_valid_q && !rsp_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				rsp_valid_q <= 1'b1;
			end
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload of the response buffer; the older item always sits in rsp_q.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_take) begin
				rsp_q <= skid_q;
			end
		end else if (accept) begin
			if (rsp_valid_q && !rsp_take) begin
				skid_q <= row_rsp;
			end else begin
				rsp_q <= row_rsp;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

endmodule

// ===== tb/sv/tb_ring_buffer_deque_top.sv =====
// Self-checking testbench for ring_buffer_deque_top: drives command items, predicts
// every response item in order and compares them field by field.
// Depends on rbd_pkg and the ring_buffer_deque_top RTL.
`timescale 1ns / 1ps

module tb_ring_buffer_deque_top;
	import rbd_pkg::*;

	// The two command codes the block treats as no operation.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	// Length of the long receiver hold-off, the final drain, and the run's
	// safety net, whose limit is very loose.
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_item_t  cmd_item  = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_item_t  rsp_item;

	ring_buffer_deque_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// Our own copy of the deque: a ring of words with a front index, a back
	// index (one past the last word) and the number of words held.
	logic signed [WORD_W-1:0] deque_words [DEPTH];
	int                       front_idx  = 0;
	int                       back_idx   = 0;
	int                       word_count = 0;

	// Responses predicted but not yet seen, oldest first.
	rsp_item_t pending_rsp[$];

	int   mismatches     = 0;
	int   cycle_count    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_on        = 1'b0;
	event hold_go;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the response to one command and updates the deque copy.
	// Pushes on a full deque and reads on an empty one leave it untouched;
	// the unused codes only report the current state.
	function automatic rsp_item_t predict_deque(cmd_item_t item);
		rsp_item_t rsp;
		rsp.read_data = '0;
		rsp.status = ST_DONE;
		case (item.command)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (word_count == DEPTH) begin
					rsp.status = ST_FULL;
				end else if (item.command == CMD_PUSH_BACK) begin
					deque_words[back_idx] = item.push_value;
					back_idx = (back_idx + 1) % DEPTH;
					word_count++;
				end else begin
					front_idx = (front_idx + DEPTH - 1) % DEPTH;
					deque_words[front_idx] = item.push_value;
					word_count++;
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT, CMD_PEEK_BACK, CMD_PEEK_FRONT: begin
				if (word_count == 0) begin
					rsp.status = ST_EMPTY;
					rsp.read_data = EMPTY_DATA;
				end else begin
					case (item.command)
						CMD_POP_BACK: begin
							back_idx = (back_idx + DEPTH - 1) % DEPTH;
							rsp.read_data = deque_words[back_idx];
							word_count--;
						end
						CMD_POP_FRONT: begin
							rsp.read_data = deque_words[front_idx];
							front_idx = (front_idx + 1) % DEPTH;
							word_count--;
						end
						CMD_PEEK_BACK: begin
							rsp.read_data = deque_words[(back_idx + DEPTH - 1) % DEPTH];
						end
						default: begin
							rsp.read_data = deque_words[front_idx];
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		rsp.is_empty = (word_count == 0);
		rsp.is_full = (word_count == DEPTH);
		rsp.occupancy = 5'(word_count);
		return rsp;
	endfunction

	// Offers one item and waits until it is taken. The sender may first go
	// idle at random. Valid is left high on return, so back-to-back items
	// keep it high with a single assignment per edge.
	task automatic send_item(input logic [2:0] code, input logic signed [WORD_W-1:0] value);
		cmd_item_t item;
		item.command = code;
		item.push_value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item <= item;
		do @(posedge clk); while (cmd_stall);
		pending_rsp.insert(pending_rsp.size(), predict_deque(item));
	endtask

	// Lowers valid and waits until every predicted response has come back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// A random command: a push with the given weight in percent, a small
	// share of unused codes, and otherwise pops (more often) and peeks.
	// Values lean towards the extremes now and then.
	function automatic cmd_item_t random_cmd(int push_weight);
		cmd_item_t item;
		int        pick;
		pick = $urandom_range(99);
		if (pick < 3) begin
			item.command = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
		end else if (pick < push_weight) begin
			item.command = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		end else begin
			case ($urandom_range(5))
				0, 1:    item.command = CMD_POP_BACK;
				2, 3:    item.command = CMD_POP_FRONT;
				4:       item.command = CMD_PEEK_BACK;
				default: item.command = CMD_PEEK_FRONT;
			endcase
		end
		case ($urandom_range(15))
			0:       item.push_value = WORD_MAX;
			1:       item.push_value = WORD_MIN;
			2:       item.push_value = '0;
			3:       item.push_value = '1;
			default: item.push_value = $urandom;
		endcase
		return item;
	endfunction

	// Reads on an empty deque at both ends, and the unused codes, straight
	// after reset. Then pairs of words, the extremes first, through every command.
	task automatic test_empty_and_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(CMD_POP_BACK, WORD_MAX);
		send_item(CMD_POP_FRONT, WORD_MIN);
		send_item(CMD_PEEK_BACK, '0);
		send_item(CMD_PEEK_FRONT, '1);
		send_item(CMD_UNUSED_LO, WORD_MAX);
		send_item(CMD_UNUSED_HI, WORD_MIN);
		send_item(CMD_PUSH_BACK, WORD_MAX);
		send_item(CMD_PUSH_FRONT, WORD_MIN);
		send_item(CMD_PEEK_BACK, '0);
		send_item(CMD_PEEK_FRONT, '0);
		send_item(CMD_POP_BACK, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_PUSH_FRONT, '1);
		send_item(CMD_PUSH_BACK, '0);
		send_item(CMD_POP_FRONT, '0);
		send_item(CMD_POP_BACK, '0);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while the sender keeps on
	// offering pushes, so the response path and the skid register fill up
	// and the block stalls its input. The pushes overrun a full deque, after
	// which it is read at both ends and emptied, one read past empty.
	task automatic test_full_under_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_go;
		for (int n = 0; n < DEPTH + 4; n++)
			send_item($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
		send_item(CMD_PEEK_BACK, '0);
		send_item(CMD_PEEK_FRONT, '0);
		send_item(CMD_UNUSED_HI, '0);
		for (int n = 0; n <= DEPTH; n++)
			send_item(n[0] ? CMD_POP_FRONT : CMD_POP_BACK, '0);
		wait_drained();
	endtask

	// Random traffic in bursts that lean towards pushing, popping or
	// neither, so the deque keeps running into full and empty.
	task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
		int        burst_left;
		int        push_weight;
		cmd_item_t item;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		burst_left = 0;
		push_weight = 50;
		for (int n = 0; n < n_items; n++) begin
			if (burst_left == 0) begin
				case ($urandom_range(2))
					0:       push_weight = 75;
					1:       push_weight = 25;
					default: push_weight = 50;
				endcase
				burst_left = $urandom_range(40, 10);
			end
			burst_left--;
			item = random_cmd(push_weight);
			send_item(item.command, item.push_value);
		end
		wait_drained();
	endtask

	// The receiver: random stalls at the current rate, plus the long
	// hold-off when it is running.
	always @(posedge clk)
		rsp_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);

	// The long hold-off counts its own cycles.
	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Every response taken is compared with the oldest prediction.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response, expected none, actual %p", $time, rsp_item);
			end else begin
				want = pending_rsp[0];
				pending_rsp.delete(0);
				check_field("read_data", want.read_data, rsp_item.read_data);
				check_field("status", want.status, rsp_item.status);
				check_field("is_empty", want.is_empty, rsp_item.is_empty);
				check_field("is_full", want.is_full, rsp_item.is_full);
				check_field("occupancy", want.occupancy, rsp_item.occupancy);
			end
		end
	end

	// Safety net against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_ring_buffer_deque_top failed");
			$finish;
		end
	end

	// Reset once, then the tests in turn: directed cases, the long hold-off,
	// and four random phases with no idling, an idle sender, a stalling
	// receiver and both. Once the last response is in, a final wait
	// catches any stray response before the verdict.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_full_under_backpressure();
		test_random_traffic(175, 0, 0);
		test_random_traffic(175, 47, 0);
		test_random_traffic(175, 0, 47);
		test_random_traffic(175, 33, 33);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("tb_ring_buffer_deque_top passed");
		end else begin
			$display("tb_ring_buffer_deque_top failed");
		end
		$finish;
	end

endmodule
